[sv/impulse_collision_resolver_defines.svh]
// Assertion helpers for the impulse collision resolver
`ifndef IMPULSE_COLLISION_RESOLVER_DEFINES_SVH
`define IMPULSE_COLLISION_RESOLVER_DEFINES_SVH

// same-cycle implication
`define ICR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ICR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/icr_pkg.sv]
`timescale 1ns / 1ps
package icr_pkg;

    localparam int NUM_STAGES          = 11;
    localparam int FRONT_STAGES        = 3;
    localparam int DIV_FIRST           = 2;
    localparam int DIV_STEPS           = 16;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = DIV_STEPS / DIV_STEPS_PER_STAGE;
    localparam int SCALE_FIRST         = DIV_FIRST + DIV_STAGES;
    localparam int SCALE_STAGES        = NUM_STAGES - SCALE_FIRST + 1;

    localparam logic [16:0] PCT_RESET  = 17'd13107;
    localparam logic [30:0] SLOP_RESET = 31'd655;
    localparam logic [17:0] ONE_Q16    = 18'd65536;

    localparam logic REG_PCT_SEL  = 1'b0;
    localparam logic REG_SLOP_SEL = 1'b1;

    typedef logic signed [31:0] vel_t;
    typedef logic signed [17:0] nrm_t;
    typedef nrm_t [2:0]         nrm3_t;
    typedef vel_t [2:0]         vel3_t;

    typedef struct packed {
        logic kill;
        logic ma_zero;
        logic mb_zero;
    } flags_t;

endpackage

[sv/icr_front.sv]
`timescale 1ns / 1ps
module icr_front
    import icr_pkg::*;
(
    input  logic                    clk,
    input  logic [FRONT_STAGES-1:0] en,
    input  vel3_t                   rel_vel,
    input  nrm3_t                   nrm,
    input  logic signed [31:0]      penetration,
    input  logic [30:0]             mass_a,
    input  logic [30:0]             mass_b,
    input  logic [16:0]             restitution_a,
    input  logic [16:0]             restitution_b,
    input  logic [16:0]             pct,
    input  logic [30:0]             slop,
    output logic [30:0]             div_num,
    output logic [31:0]             div_den,
    output logic [35:0]             s_out,
    output logic [31:0]             c_out,
    output flags_t                  flags_out,
    output nrm3_t                   nrm_out
);

    logic signed [49:0] prod_reg [3];
    logic [30:0]        d1_reg;
    logic [16:0]        e1_reg;
    logic               ma0_1_reg, mb0_1_reg;
    nrm3_t              n1_reg;
    logic [30:0]        mb1_reg;
    logic [31:0]        sum1_reg;

    logic signed [51:0] vn2_reg;
    logic [47:0]        c2_reg;
    logic [16:0]        e2_reg;
    logic               ma0_2_reg, mb0_2_reg;
    nrm3_t              n2_reg;

    logic [35:0]        s3_reg;
    logic [31:0]        c3_reg;
    flags_t             f3_reg;
    nrm3_t              n3_reg;

    logic signed [32:0] dd;
    logic [30:0]        d1_next;
    logic [51:0]        negv;
    logic [33:0]        mag;
    logic [17:0]        ep;
    logic [51:0]        sprod;
    logic               sep;

    always_comb
    begin
        dd      = $signed({penetration[31], penetration}) - $signed({2'b00, slop});
        d1_next = (!dd[32] && (dd != '0)) ? dd[30:0] : '0;
        negv    = 52'(0) - 52'(vn2_reg);
        mag     = negv[49:16];
        ep      = ONE_Q16 + 18'(e2_reg);
        sprod   = 52'(ep) * 52'(mag);
        sep     = !vn2_reg[51] && (vn2_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= $signed(rel_vel[i]) * $signed(nrm[i]);
            end
            d1_reg    <= d1_next;
            e1_reg    <= (restitution_a < restitution_b) ? restitution_a : restitution_b;
            ma0_1_reg <= (mass_a == '0);
            mb0_1_reg <= (mass_b == '0);
            n1_reg    <= nrm;
            mb1_reg   <= mass_b;
            sum1_reg  <= 32'(mass_a) + 32'(mass_b);
        end
        if (en[1])
        begin
            vn2_reg   <= 52'(prod_reg[0]) + 52'(prod_reg[1]) + 52'(prod_reg[2]);
            c2_reg    <= 48'(d1_reg) * 48'(pct);
            e2_reg    <= e1_reg;
            ma0_2_reg <= ma0_1_reg;
            mb0_2_reg <= mb0_1_reg;
            n2_reg    <= n1_reg;
        end
        if (en[2])
        begin
            s3_reg         <= sprod[51:16];
            c3_reg         <= c2_reg[47:16];
            f3_reg.kill    <= sep || (ma0_2_reg && mb0_2_reg);
            f3_reg.ma_zero <= ma0_2_reg;
            f3_reg.mb_zero <= mb0_2_reg;
            n3_reg         <= n2_reg;
        end
    end

    assign div_num   = mb1_reg;
    assign div_den   = sum1_reg;
    assign s_out     = s3_reg;
    assign c_out     = c3_reg;
    assign flags_out = f3_reg;
    assign nrm_out   = n3_reg;

endmodule

[sv/icr_div.sv]
`timescale 1ns / 1ps
module icr_div
    import icr_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] en,
    input  logic [30:0]           num,
    input  logic [31:0]           den,
    output logic [15:0]           quo,
    output logic                  rem_zero
);

    // quotient of num * 2^16 / den, num < den, restoring, two bits a stage
    logic [31:0] r_reg [DIV_STAGES];
    logic [31:0] d_reg [DIV_STAGES];
    logic [15:0] q_reg [DIV_STAGES];

    logic [31:0] r_next [DIV_STAGES];
    logic [15:0] q_next [DIV_STAGES];
    logic [31:0] d_in   [DIV_STAGES];
    logic [32:0] r2;

    always_comb
    begin
        r2 = '0;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (j == 0)
            begin
                r_next[j] = 32'(num);
                q_next[j] = '0;
                d_in[j]   = den;
            end
            else
            begin
                r_next[j] = r_reg[j-1];
                q_next[j] = q_reg[j-1];
                d_in[j]   = d_reg[j-1];
            end
            for (int k = 0; k < DIV_STEPS_PER_STAGE; k++)
            begin
                r2 = {r_next[j], 1'b0};
                if (r2 >= {1'b0, d_in[j]})
                begin
                    r2        = r2 - {1'b0, d_in[j]};
                    q_next[j] = {q_next[j][14:0], 1'b1};
                end
                else
                begin
                    q_next[j] = {q_next[j][14:0], 1'b0};
                end
                r_next[j] = r2[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (en[j])
            begin
                r_reg[j] <= r_next[j];
                q_reg[j] <= q_next[j];
                d_reg[j] <= d_in[j];
            end
        end
    end

    assign quo      = q_reg[DIV_STAGES-1];
    assign rem_zero = (r_reg[DIV_STAGES-1] == '0);

endmodule

[sv/icr_scale.sv]
`timescale 1ns / 1ps
module icr_scale
    import icr_pkg::*;
(
    input  logic                    clk,
    input  logic [SCALE_STAGES-1:0] en,
    input  logic [35:0]             s_in,
    input  logic [31:0]             c_in,
    input  flags_t                  flags_in,
    input  nrm3_t                   nrm_in,
    input  logic [15:0]             quo,
    input  logic                    rem_zero,
    output logic [31:0]             res [12]
);

    logic [35:0] ja_reg, jb_reg;
    logic [31:0] ca_reg, cb_reg;
    logic        kill_reg;
    nrm3_t       n_reg;
    logic [31:0] out_reg [12];

    logic [16:0] wa, wb;
    logic [52:0] pja, pjb;
    logic [48:0] pca, pcb;

    function automatic logic [31:0] scale_out(nrm_t n, logic [35:0] mag, logic neg);
        logic [17:0] nm;
        logic [53:0] prod;
        logic [37:0] p;
        logic        sgn;
        logic [31:0] r;
        nm   = n[17] ? 18'(-n) : 18'(n);
        prod = 54'(nm) * 54'(mag);
        p    = prod[53:16];
        sgn  = n[17] ^ neg;
        if (p == '0)
            r = '0;
        else if (sgn)
            r = (p > 38'h80000000) ? 32'h80000000 : 32'(38'(0) - p);
        else
            r = (p > 38'h7FFFFFFF) ? 32'h7FFFFFFF : p[31:0];
        return r;
    endfunction

    always_comb
    begin
        if (flags_in.ma_zero)
            wa = '0;
        else if (flags_in.mb_zero)
            wa = 17'(ONE_Q16);
        else
            wa = {1'b0, quo};
        if (flags_in.mb_zero)
            wb = '0;
        else if (flags_in.ma_zero)
            wb = 17'(ONE_Q16);
        else
            wb = 17'd65535 - {1'b0, quo} + 17'(rem_zero);
        pja = 53'(s_in) * 53'(wa);
        pjb = 53'(s_in) * 53'(wb);
        pca = 49'(c_in) * 49'(wa);
        pcb = 49'(c_in) * 49'(wb);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ja_reg   <= pja[51:16];
            jb_reg   <= pjb[51:16];
            ca_reg   <= pca[47:16];
            cb_reg   <= pcb[47:16];
            kill_reg <= flags_in.kill;
            n_reg    <= nrm_in;
        end
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_reg[i]   <= kill_reg ? '0 : scale_out(n_reg[i], ja_reg, 1'b1);
                out_reg[3+i] <= kill_reg ? '0 : scale_out(n_reg[i], jb_reg, 1'b0);
                out_reg[6+i] <= kill_reg ? '0 : scale_out(n_reg[i], 36'(ca_reg), 1'b1);
                out_reg[9+i] <= kill_reg ? '0 : scale_out(n_reg[i], 36'(cb_reg), 1'b0);
            end
        end
    end

    assign res = out_reg;

endmodule

[sv/impulse_collision_resolver.sv]
`timescale 1ns / 1ps
// Impulse collision resolver: one two-body contact in, one word of deltas out.
// Input channel: in_valid / in_stall with the contact fields; a word is taken
// on a clock edge with in_valid high and in_stall low. Output channel:
// out_valid / out_stall with twelve Q16.16 velocity and position deltas.
// One word per cycle is sustained while out_stall stays low. Three front
// stages form the dot product, impulse and correction, an 8-stage restoring
// divider (two quotient bits a stage) forms the mass share, and two stages
// weight and scale by the normal into the output reg. Each stage holds its
// own valid bit; a stage loads when it is empty or the one after it moves, so
// bubbles close up while the output is stalled and in_stall rises only once
// every stage holds a word. Reset clears all valid bits and loads percent 0.2
// and slop 0.01. Registers sit on an APB port (0x0 percent, 0x4 slop); the
// user must write them only when idle, as the block does not enforce this.
module impulse_collision_resolver
    import icr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] rel_vel_x,
    input  logic signed [31:0] rel_vel_y,
    input  logic signed [31:0] rel_vel_z,
    input  logic signed [17:0] normal_x,
    input  logic signed [17:0] normal_y,
    input  logic signed [17:0] normal_z,
    input  logic signed [31:0] penetration,
    input  logic [30:0]        mass_a,
    input  logic [30:0]        mass_b,
    input  logic [16:0]        restitution_a,
    input  logic [16:0]        restitution_b,
    input  logic               batch_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] dvel_a_x,
    output logic signed [31:0] dvel_a_y,
    output logic signed [31:0] dvel_a_z,
    output logic signed [31:0] dvel_b_x,
    output logic signed [31:0] dvel_b_y,
    output logic signed [31:0] dvel_b_z,
    output logic signed [31:0] dpos_a_x,
    output logic signed [31:0] dpos_a_y,
    output logic signed [31:0] dpos_a_z,
    output logic signed [31:0] dpos_b_x,
    output logic signed [31:0] dpos_b_y,
    output logic signed [31:0] dpos_b_z
);

    logic [16:0]           pct_reg;
    logic [30:0]           slop_reg;
    logic [NUM_STAGES:1]   vld_reg;
    logic [NUM_STAGES:1]   en;

    logic [30:0]           div_num;
    logic [31:0]           div_den;
    logic [35:0]           s3;
    logic [31:0]           c3;
    flags_t                f3;
    nrm3_t                 n3;
    logic [15:0]           quo;
    logic                  rem_zero;
    logic [31:0]           res [12];

    logic [35:0]           dl_s_reg [FRONT_STAGES+1:SCALE_FIRST-1];
    logic [31:0]           dl_c_reg [FRONT_STAGES+1:SCALE_FIRST-1];
    flags_t                dl_f_reg [FRONT_STAGES+1:SCALE_FIRST-1];
    nrm3_t                 dl_n_reg [FRONT_STAGES+1:SCALE_FIRST-1];

    vel3_t                 rv_in;
    nrm3_t                 n_in;

    assign rv_in  = {rel_vel_z, rel_vel_y, rel_vel_x};
    assign n_in   = {normal_z, normal_y, normal_x};
    assign pready = 1'b1;

    // batch_last is taken in but unused by the math
    always_comb
    begin
        unique case (paddr[2])
            REG_PCT_SEL:  prdata = {15'b0, pct_reg};
            REG_SLOP_SEL: prdata = {1'b0, slop_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg  <= PCT_RESET;
            slop_reg <= SLOP_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_PCT_SEL:  pct_reg  <= pwdata[16:0];
                REG_SLOP_SEL: slop_reg <= pwdata[30:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        en[NUM_STAGES] = !vld_reg[NUM_STAGES] || !out_stall;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[1];
    assign out_valid = vld_reg[NUM_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
                vld_reg[1] <= in_valid && !batch_last && 1'b0 || in_valid;
            for (int k = 2; k <= NUM_STAGES; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = FRONT_STAGES + 1; k < SCALE_FIRST; k++)
        begin
            if (en[k])
            begin
                if (k == FRONT_STAGES + 1)
                begin
                    dl_s_reg[k] <= s3;
                    dl_c_reg[k] <= c3;
                    dl_f_reg[k] <= f3;
                    dl_n_reg[k] <= n3;
                end
                else
                begin
                    dl_s_reg[k] <= dl_s_reg[k-1];
                    dl_c_reg[k] <= dl_c_reg[k-1];
                    dl_f_reg[k] <= dl_f_reg[k-1];
                    dl_n_reg[k] <= dl_n_reg[k-1];
                end
            end
        end
    end

    icr_front u_front (
        .clk           (clk),
        .en            (en[FRONT_STAGES:1]),
        .rel_vel       (rv_in),
        .nrm           (n_in),
        .penetration   (penetration),
        .mass_a        (mass_a),
        .mass_b        (mass_b),
        .restitution_a (restitution_a),
        .restitution_b (restitution_b),
        .pct           (pct_reg),
        .slop          (slop_reg),
        .div_num       (div_num),
        .div_den       (div_den),
        .s_out         (s3),
        .c_out         (c3),
        .flags_out     (f3),
        .nrm_out       (n3)
    );

    icr_div u_div (
        .clk      (clk),
        .en       (en[SCALE_FIRST-1:DIV_FIRST]),
        .num      (div_num),
        .den      (div_den),
        .quo      (quo),
        .rem_zero (rem_zero)
    );

    icr_scale u_scale (
        .clk      (clk),
        .en       (en[NUM_STAGES:SCALE_FIRST]),
        .s_in     (dl_s_reg[SCALE_FIRST-1]),
        .c_in     (dl_c_reg[SCALE_FIRST-1]),
        .flags_in (dl_f_reg[SCALE_FIRST-1]),
        .nrm_in   (dl_n_reg[SCALE_FIRST-1]),
        .quo      (quo),
        .rem_zero (rem_zero),
        .res      (res)
    );

    assign dvel_a_x = res[0];
    assign dvel_a_y = res[1];
    assign dvel_a_z = res[2];
    assign dvel_b_x = res[3];
    assign dvel_b_y = res[4];
    assign dvel_b_z = res[5];
    assign dpos_a_x = res[6];
    assign dpos_a_y = res[7];
    assign dpos_a_z = res[8];
    assign dpos_b_x = res[9];
    assign dpos_b_y = res[10];
    assign dpos_b_z = res[11];

endmodule

[sv/icr_checker.sv]
`timescale 1ns / 1ps
`include "impulse_collision_resolver_defines.svh"
module icr_checker
    import icr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] dvel_a_x,
    input logic [31:0] dvel_b_x,
    input logic [31:0] dpos_a_y,
    input logic [31:0] dpos_b_y,
    input logic [31:0] dpos_b_z
);

    `ICR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(dvel_a_x) && $stable(dpos_b_z), "stalled output word changed")
    `ICR_ASSERT_IMPL(a_in_stall_full, in_stall, out_valid && out_stall, "input stalled while output moves")
    `ICR_ASSERT_IMPL(a_dvel_opposed, out_valid && (dvel_a_x != '0) && (dvel_b_x != '0), dvel_a_x[31] != dvel_b_x[31], "velocity deltas not opposed")
    `ICR_ASSERT_IMPL(a_dpos_opposed, out_valid && (dpos_a_y != '0) && (dpos_b_y != '0), dpos_a_y[31] != dpos_b_y[31], "position deltas not opposed")

endmodule

bind impulse_collision_resolver icr_checker u_icr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dvel_a_x  (dvel_a_x),
    .dvel_b_x  (dvel_b_x),
    .dpos_a_y  (dpos_a_y),
    .dpos_b_y  (dpos_b_y),
    .dpos_b_z  (dpos_b_z)
);

[tb/impulse_collision_resolver_tb.sv]
`timescale 1ns / 1ps
module impulse_collision_resolver_tb;
    import icr_pkg::*;

    localparam logic [2:0] ADDR_PCT  = 3'd0;
    localparam logic [2:0] ADDR_SLOP = 3'd4;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 30;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic signed [31:0] rvx, rvy, rvz;
        logic signed [17:0] nx, ny, nz;
        logic signed [31:0] pen;
        logic [30:0]        ma, mb;
        logic [16:0]        ra, rb;
        logic               last;
    } contact_t;

    typedef logic [11:0][31:0] deltas_t;

    typedef struct {
        contact_t c;
        bit       typed;
        deltas_t  want;
    } stim_row_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [31:0] rel_vel_x, rel_vel_y, rel_vel_z, penetration;
    logic signed [17:0] normal_x, normal_y, normal_z;
    logic [30:0] mass_a, mass_b;
    logic [16:0] restitution_a, restitution_b;
    logic batch_last;
    logic signed [31:0] dvel_a_x, dvel_a_y, dvel_a_z, dvel_b_x, dvel_b_y, dvel_b_z;
    logic signed [31:0] dpos_a_x, dpos_a_y, dpos_a_z, dpos_b_x, dpos_b_y, dpos_b_z;

    impulse_collision_resolver dut (.*);

    logic [16:0] cur_pct;
    logic [30:0] cur_slop;
    deltas_t     pending_deltas[$];
    int          errors;
    int          cycles;
    idle_mode_e  idle_mode;
    int          hold_left;
    string       field_names[12] = '{"dvel_a_x", "dvel_a_y", "dvel_a_z",
                                     "dvel_b_x", "dvel_b_y", "dvel_b_z",
                                     "dpos_a_x", "dpos_a_y", "dpos_a_z",
                                     "dpos_b_x", "dpos_b_y", "dpos_b_z"};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] scale_normal(longint n, logic [63:0] mag, bit neg);
        logic [63:0] nm;
        logic [63:0] p;
        bit          flip;
        nm = (n < 0) ? 64'(-n) : 64'(n);
        p = (nm * mag) >> 16;
        flip = (n < 0) != neg;
        if (p == 0)
            return 32'd0;
        if (flip)
        begin
            if (p > 64'h8000_0000)
                p = 64'h8000_0000;
            return 32'(64'd0 - p);
        end
        if (p > 64'h7FFF_FFFF)
            p = 64'h7FFF_FFFF;
        return p[31:0];
    endfunction

    function automatic logic [63:0] mass_share(logic [63:0] mine, logic [63:0] other);
        if (mine == 0)
            return 64'd0;
        if (other == 0)
            return 64'd65536;
        return (other << 16) / (mine + other);
    endfunction

    function automatic deltas_t resolve_contact(contact_t c);
        deltas_t     r;
        longint      n[3];
        longint      vn, dd;
        logic [63:0] e, mag, s, wa, wb, ja, jb, d, cc, ca, cb;
        r = '0;
        n[0] = longint'(c.nx);
        n[1] = longint'(c.ny);
        n[2] = longint'(c.nz);
        if (c.ma == 0 && c.mb == 0)
            return r;
        vn = longint'(c.rvx) * n[0] + longint'(c.rvy) * n[1] + longint'(c.rvz) * n[2];
        if (vn > 0)
            return r;
        e = (c.ra < c.rb) ? 64'(c.ra) : 64'(c.rb);
        mag = 64'(-vn) >> 16;
        s = ((64'd65536 + e) * mag) >> 16;
        wa = mass_share(64'(c.ma), 64'(c.mb));
        wb = mass_share(64'(c.mb), 64'(c.ma));
        ja = (s * wa) >> 16;
        jb = (s * wb) >> 16;
        dd = longint'(c.pen) - longint'(cur_slop);
        d = (dd > 0) ? 64'(dd) : 64'd0;
        cc = (d * 64'(cur_pct)) >> 16;
        ca = (cc * wa) >> 16;
        cb = (cc * wb) >> 16;
        for (int i = 0; i < 3; i++)
        begin
            r[i]     = scale_normal(n[i], ja, 1'b1);
            r[3 + i] = scale_normal(n[i], jb, 1'b0);
            r[6 + i] = scale_normal(n[i], ca, 1'b1);
            r[9 + i] = scale_normal(n[i], cb, 1'b0);
        end
        return r;
    endfunction

    function automatic logic signed [17:0] rand_normal();
        if ($urandom_range(9) == 0)
            return 18'($urandom);
        return 18'(int'($urandom_range(131072)) - 65536);
    endfunction

    function automatic logic [30:0] rand_mass();
        case ($urandom_range(5))
            0: return 31'd0;
            1: return 31'($urandom);
            2: return 31'($urandom_range(1 << 20));
            default: return 31'($urandom_range(1 << 18, 1));
        endcase
    endfunction

    function automatic logic [16:0] rand_bounce();
        if ($urandom_range(7) == 0)
            return 17'($urandom);
        return 17'($urandom_range(65536));
    endfunction

    function automatic logic signed [31:0] rand_vel();
        if ($urandom_range(2) == 0)
            return 32'($urandom);
        return 32'(int'($urandom_range(1 << 23)) - (1 << 22));
    endfunction

    function automatic contact_t rand_contact();
        contact_t c;
        longint   vn;
        c.rvx = rand_vel();
        c.rvy = rand_vel();
        c.rvz = rand_vel();
        c.nx = rand_normal();
        c.ny = rand_normal();
        c.nz = rand_normal();
        c.pen = ($urandom_range(2) == 0) ? 32'($urandom)
                                          : 32'(int'($urandom_range(1 << 22)) - (1 << 18));
        c.ma = rand_mass();
        c.mb = rand_mass();
        c.ra = rand_bounce();
        c.rb = rand_bounce();
        c.last = $urandom_range(1);
        vn = longint'(c.rvx) * c.nx + longint'(c.rvy) * c.ny + longint'(c.rvz) * c.nz;
        if (vn > 0 && $urandom_range(9) < 8)
        begin
            c.rvx = -c.rvx;
            c.rvy = -c.rvy;
            c.rvz = -c.rvz;
        end
        return c;
    endfunction

    function automatic contact_t mk(longint vx, longint vy, longint vz,
                                    longint nx, longint ny, longint nz, longint pen,
                                    longint ma, longint mb, longint ra, longint rb);
        contact_t c;
        c.rvx = 32'(vx);
        c.rvy = 32'(vy);
        c.rvz = 32'(vz);
        c.nx = 18'(nx);
        c.ny = 18'(ny);
        c.nz = 18'(nz);
        c.pen = 32'(pen);
        c.ma = 31'(ma);
        c.mb = 31'(mb);
        c.ra = 17'(ra);
        c.rb = 17'(rb);
        c.last = 1'b0;
        return c;
    endfunction

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_PCT)
            cur_pct = data[16:0];
        else
            cur_slop = data[30:0];
    endtask

    task automatic set_tuning(logic [16:0] pct, logic [30:0] slop);
        wait (pending_deltas.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        apb_write(ADDR_PCT, 32'(pct));
        apb_write(ADDR_SLOP, 32'(slop));
    endtask

    // one word, held until taken
    task automatic send_contact(contact_t c, bit typed, deltas_t want);
        in_valid <= 1'b1;
        rel_vel_x <= c.rvx;
        rel_vel_y <= c.rvy;
        rel_vel_z <= c.rvz;
        normal_x <= c.nx;
        normal_y <= c.ny;
        normal_z <= c.nz;
        penetration <= c.pen;
        mass_a <= c.ma;
        mass_b <= c.mb;
        restitution_a <= c.ra;
        restitution_b <= c.rb;
        batch_last <= c.last;
        do
            @(posedge clk);
        while (in_stall);
        pending_deltas.push_back(typed ? want : resolve_contact(c));
    endtask

    task automatic idle_gaps();
        if (idle_mode == IDLE_SENDER)
        begin
            while ($urandom_range(99) < 76)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        else if (idle_mode == IDLE_BOTH)
        begin
            while ($urandom_range(99) < 35)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    always @(posedge clk)
    begin
        deltas_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {dpos_b_z, dpos_b_y, dpos_b_x, dpos_a_z, dpos_a_y, dpos_a_x,
                   dvel_b_z, dvel_b_y, dvel_b_x, dvel_a_z, dvel_a_y, dvel_a_x};
            if (pending_deltas.size() == 0)
            begin
                $error("unexpected word out");
                errors++;
            end
            else
            begin
                want = pending_deltas.pop_front();
                for (int i = 0; i < 12; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        $error("%s expected %0d got %0d", field_names[i],
                               $signed(want[i]), $signed(got[i]));
                        errors++;
                    end
                end
            end
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (idle_mode == IDLE_RECEIVER)
            out_stall <= ($urandom_range(99) < 76);
        else if (idle_mode == IDLE_BOTH)
            out_stall <= ($urandom_range(99) < 35);
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        deltas_t   z;
        int        n;
        z = '0;
        errors = 0;
        cycles = 0;
        hold_left = 0;
        idle_mode = IDLE_NONE;
        cur_pct = PCT_RESET;
        cur_slop = SLOP_RESET;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        rel_vel_x = '0;
        rel_vel_y = '0;
        rel_vel_z = '0;
        normal_x = '0;
        normal_y = '0;
        normal_z = '0;
        penetration = '0;
        mass_a = '0;
        mass_b = '0;
        restitution_a = '0;
        restitution_b = '0;
        batch_last = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // both immovable
        row.c = mk(-2147483648, 2147483647, -1, 65536, -65536, 65536, 2147483647,
                   0, 0, 65536, 65536);
        row.typed = 1;
        row.want = z;
        rows.push_back(row);
        // separating
        row.c = mk(65536, 0, 0, 65536, 0, 0, 655360, 65536, 65536, 0, 0);
        row.want = z;
        rows.push_back(row);
        // head-on, equal masses, no bounce
        row.c = mk(-65536, 0, 0, 65536, 0, 0, 0, 65536, 65536, 0, 0);
        row.want = z;
        row.want[0] = -32'sd32768;
        row.want[3] = 32'd32768;
        rows.push_back(row);
        // saturation on A, B immovable
        row.c = mk(-2147483648, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536, 65536);
        row.want = z;
        row.want[0] = 32'h8000_0000;
        rows.push_back(row);
        row.typed = 0;
        row.c = mk(0, 0, 0, 0, 65536, 0, 655360, 65536, 131072, 0, 0);
        rows.push_back(row);
        row.c = mk(0, 0, 0, 0, 0, -65536, 2147483647, 2147483647, 2147483647, 0, 0);
        rows.push_back(row);
        row.c = mk(2147483647, -2147483648, 2147483647, -65536, 65536, -65536,
                   -2147483648, 1, 2147483647, 65536, 131071);
        rows.push_back(row);
        row.c = mk(-2147483648, -2147483648, -2147483648, 131071, 131071, 131071,
                   2147483647, 0, 65536, 131071, 131071);
        rows.push_back(row);
        row.c = mk(2147483647, 2147483647, 2147483647, -131072, -131072, -131072,
                   2147483647, 2147483647, 0, 131071, 0);
        rows.push_back(row);
        row.c = mk(-1, -1, -1, 1, 1, 1, 656, 1, 1, 0, 65536);
        rows.push_back(row);
        row.c = mk(-3000000, 1200000, 50000, 46341, -46341, 0, 1000000,
                   200000, 70000, 32768, 13107);
        row.c.last = 1'b1;
        rows.push_back(row);
        row.c = mk(65536, 65536, 0, 0, 0, 65536, 655, 65536, 65536, 65536, 65536);
        rows.push_back(row);

        @(posedge clk);
        foreach (rows[i])
            send_contact(rows[i].c, rows[i].typed, rows[i].want);
        in_valid <= 1'b0;

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: set_tuning(17'd0, 31'd0);
                1: set_tuning(17'd65536, 31'h7FFF_FFFF);
                2: set_tuning(17'h1FFFF, SLOP_RESET);
                3: set_tuning(PCT_RESET, 31'd0);
                8: set_tuning(PCT_RESET, SLOP_RESET);
                default: set_tuning(17'($urandom), ($urandom_range(1) == 1) ? 31'($urandom)
                                                     : 31'($urandom_range(1 << 20)));
            endcase
            idle_mode = idle_mode_e'(ph % 4);
            if (ph == 4)
                hold_left <= 300;
            @(posedge clk);
            n = 180;
            for (int k = 0; k < n; k++)
            begin
                idle_gaps();
                send_contact(rand_contact(), 1'b0, z);
            end
            in_valid <= 1'b0;
            if (ph == 5)
                wait (pending_deltas.size() == 0);
        end
        in_valid <= 1'b0;
        wait (pending_deltas.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/icr_pkg.sv
sv/icr_front.sv
sv/icr_div.sv
sv/icr_scale.sv
sv/impulse_collision_resolver.sv
sv/icr_checker.sv
tb/impulse_collision_resolver_tb.sv
